/* rtl/apos_pkg.sv */
// Package for the alternating pulse output sequencer.
// Holds register indexes, mode and channel codes, reset values and fixed levels.
// No dependencies.
package apos_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] RegRestFactor = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPeakFactor = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBaseTicks  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRunMode    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRampStep   = 3'd4;

  // Configuration reset values
  localparam logic [7:0]  RestFactorRst = 8'd63;
  localparam logic [7:0]  PeakFactorRst = 8'd33;
  localparam logic [15:0] BaseTicksRst  = 16'd4097;
  localparam logic [1:0]  RunModeRst    = 2'd0;
  localparam logic [3:0]  RampStepRst   = 4'd10;

  // Run modes
  localparam logic [1:0] ModeRamp     = 2'd0;
  localparam logic [1:0] ModeExternal = 2'd1;

  // Active channel codes
  localparam logic [1:0] ChanNone    = 2'd0;
  localparam logic [1:0] ChanInvalid = 2'd1;
  localparam logic [1:0] ChanA       = 2'd2;
  localparam logic [1:0] ChanB       = 2'd3;

  // Fixed levels and counts
  localparam logic [2:0]  HoldEvents = 3'd5;
  localparam logic [11:0] RampTop    = 12'd4080;
  localparam logic [11:0] InvertBase = 12'd3300;
  localparam logic [7:0]  UnitFactor = 8'd1;

endpackage

/* rtl/alternating_pulse_output_sequencer.sv */
// Alternating pulse output sequencer: phase state, DAC ramp and timer reload; uses apos_pkg.
// An accepted transaction is captured in the input register, then one pass of phase
// logic and the reload multiplier writes its result into the result register.
// Throughput: one transaction per cycle while the result side is not stalled; the result
// register and input register decouple the two sides. Reset clears all sequencer state
// and restores the configuration defaults; there is no clearing pass.
module alternating_pulse_output_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [apos_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [apos_pkg::CfgDataW-1:0]     cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [11:0]                       external_level_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [11:0]                       dac_value_o,
  output logic                              dac_write_o,
  output logic                              gate_pin_o,
  output logic                              channel_a_pin_o,
  output logic                              channel_b_pin_o,
  output logic [15:0]                       reload_value_o,
  output logic                              reload_write_o,
  output logic                              pwm_enable_o,
  output logic                              period_done_o
);

  // Configuration registers
  logic [7:0]  rest_factor_q;
  logic [7:0]  peak_factor_q;
  logic [15:0] base_ticks_q;
  logic [1:0]  run_mode_q;
  logic [3:0]  ramp_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_factor_q <= apos_pkg::RestFactorRst;
      peak_factor_q <= apos_pkg::PeakFactorRst;
      base_ticks_q  <= apos_pkg::BaseTicksRst;
      run_mode_q    <= apos_pkg::RunModeRst;
      ramp_step_q   <= apos_pkg::RampStepRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        apos_pkg::RegRestFactor: rest_factor_q <= cfg_data_i[7:0];
        apos_pkg::RegPeakFactor: peak_factor_q <= cfg_data_i[7:0];
        apos_pkg::RegBaseTicks:  base_ticks_q  <= cfg_data_i;
        apos_pkg::RegRunMode:    run_mode_q    <= cfg_data_i[1:0];
        apos_pkg::RegRampStep:   ramp_step_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // Input register and flow control
  logic        in_valid_q;
  logic [11:0] ext_q;
  logic        out_valid_q;
  logic        advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ext_q <= external_level_i;
    end
  end

  // Sequencer state
  logic [2:0]  hold_count_q, hold_count_d;
  logic [1:0]  active_ch_q, active_ch_d;
  logic        voltage_on_q, voltage_on_d;
  logic        gate_q, gate_d;
  logic        polarity_q, polarity_d;
  logic [11:0] ramp_level_q, ramp_level_d;
  logic        ramp_down_q, ramp_down_d;
  logic [11:0] dac_hold_q, dac_hold_d;

  // Ramp move for the positive pulse, saturated to the 12-bit range
  logic [12:0] ramp_sum;
  logic [11:0] ramp_up_lvl;
  logic [11:0] ramp_dn_lvl;
  logic [11:0] ramp_new;
  logic        ramp_dir1;
  logic        ramp_dir2;
  logic [11:0] invert_lvl;

  assign ramp_sum    = {1'b0, ramp_level_q} + 13'(ramp_step_q);
  assign ramp_up_lvl = ramp_sum[12] ? 12'hFFF : ramp_sum[11:0];
  assign ramp_dn_lvl = (ramp_level_q < 12'(ramp_step_q)) ? 12'd0
                                                         : ramp_level_q - 12'(ramp_step_q);
  assign ramp_new    = ramp_down_q ? ramp_dn_lvl : ramp_up_lvl;
  assign ramp_dir1   = ramp_down_q ^ (ramp_new > apos_pkg::RampTop);
  assign ramp_dir2   = ramp_dir1 ^ (ramp_dir1 && (ramp_new < 12'(ramp_step_q)));

  // Inverted pulse level, clamped at zero
  assign invert_lvl = (ramp_level_q >= apos_pkg::InvertBase) ? 12'd0
                                                             : apos_pkg::InvertBase - ramp_level_q;

  // Phase logic
  logic [7:0] factor_sel;
  logic       dwr, rwr, pwm, done;

  always_comb begin
    hold_count_d = hold_count_q;
    active_ch_d  = active_ch_q;
    voltage_on_d = voltage_on_q;
    gate_d       = gate_q;
    polarity_d   = polarity_q;
    ramp_level_d = ramp_level_q;
    ramp_down_d  = ramp_down_q;
    dac_hold_d   = dac_hold_q;
    factor_sel   = apos_pkg::UnitFactor;
    dwr          = 1'b0;
    rwr          = 1'b0;
    pwm          = 1'b0;
    done         = 1'b0;

    if (hold_count_q != 3'd0) begin
      // count down the hold
      hold_count_d = hold_count_q - 3'd1;
    end else if (active_ch_q != apos_pkg::ChanNone) begin
      if (voltage_on_q) begin
        // voltage off
        gate_d       = 1'b0;
        dac_hold_d   = 12'd0;
        dwr          = 1'b1;
        rwr          = 1'b1;
        voltage_on_d = 1'b0;
      end else begin
        // channel off, then hold
        active_ch_d  = apos_pkg::ChanNone;
        factor_sel   = rest_factor_q;
        rwr          = 1'b1;
        hold_count_d = apos_pkg::HoldEvents;
        done         = 1'b1;
      end
    end else if (!gate_q) begin
      // pre-open
      gate_d     = 1'b1;
      dac_hold_d = 12'd0;
      dwr        = 1'b1;
      rwr        = 1'b1;
    end else begin
      // output on, alternate channels
      gate_d = 1'b0;
      if (polarity_q) begin
        if (run_mode_q == apos_pkg::ModeRamp) begin
          ramp_level_d = ramp_new;
          ramp_down_d  = ramp_dir2;
          dac_hold_d   = ramp_new;
        end else if (run_mode_q == apos_pkg::ModeExternal) begin
          dac_hold_d = ext_q;
        end
        polarity_d  = 1'b0;
        active_ch_d = apos_pkg::ChanB;
      end else begin
        if (run_mode_q == apos_pkg::ModeRamp) begin
          dac_hold_d = invert_lvl;
        end else if (run_mode_q == apos_pkg::ModeExternal) begin
          dac_hold_d = ext_q;
        end
        polarity_d  = 1'b1;
        active_ch_d = apos_pkg::ChanA;
      end
      dwr          = 1'b1;
      voltage_on_d = 1'b1;
      factor_sel   = peak_factor_q;
      rwr          = 1'b1;
      pwm          = 1'b1;
    end
  end

  // Timer reload: factor*base/8-1, saturated to 16 bits; zero if no reload or quotient is 0
  logic [23:0] product;
  logic [20:0] quot;
  logic [20:0] quot_m1;
  logic [15:0] reload;

  assign product = 24'(factor_sel) * 24'(base_ticks_q);
  assign quot    = product[23:3];
  assign quot_m1 = quot - 21'd1;

  always_comb begin
    if (!rwr || quot == 21'd0) begin
      reload = 16'd0;
    end else if (quot_m1[20:16] != 5'd0) begin
      reload = 16'hFFFF;
    end else begin
      reload = quot_m1[15:0];
    end
  end

  // Commit state on each processed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_count_q <= 3'd0;
      active_ch_q  <= apos_pkg::ChanNone;
      voltage_on_q <= 1'b0;
      gate_q       <= 1'b0;
      polarity_q   <= 1'b0;
      ramp_level_q <= 12'd0;
      ramp_down_q  <= 1'b0;
      dac_hold_q   <= 12'd0;
    end else if (advance) begin
      hold_count_q <= hold_count_d;
      active_ch_q  <= active_ch_d;
      voltage_on_q <= voltage_on_d;
      gate_q       <= gate_d;
      polarity_q   <= polarity_d;
      ramp_level_q <= ramp_level_d;
      ramp_down_q  <= ramp_down_d;
      dac_hold_q   <= dac_hold_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [11:0] dac_value_q;
  logic        dac_write_q, gate_pin_q, chan_a_q, chan_b_q;
  logic [15:0] reload_value_q;
  logic        reload_write_q, pwm_enable_q, period_done_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dac_value_q    <= dac_hold_d;
      dac_write_q    <= dwr;
      gate_pin_q     <= gate_d;
      chan_a_q       <= (active_ch_d == apos_pkg::ChanA);
      chan_b_q       <= (active_ch_d == apos_pkg::ChanB);
      reload_value_q <= reload;
      reload_write_q <= rwr;
      pwm_enable_q   <= pwm;
      period_done_q  <= done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign dac_value_o     = dac_value_q;
  assign dac_write_o     = dac_write_q;
  assign gate_pin_o      = gate_pin_q;
  assign channel_a_pin_o = chan_a_q;
  assign channel_b_pin_o = chan_b_q;
  assign reload_value_o  = reload_value_q;
  assign reload_write_o  = reload_write_q;
  assign pwm_enable_o    = pwm_enable_q;
  assign period_done_o   = period_done_q;

`ifndef SYNTHESIS
  // A hold is only loaded after the channel is dropped
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_count_q != 3'd0) |-> (active_ch_q == apos_pkg::ChanNone && !voltage_on_q))
    else $error("hold count running with an active channel");

  a_hold_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_count_q <= apos_pkg::HoldEvents)
    else $error("hold count above load value");

  // Voltage on needs a channel, and never the unused code
  a_volt_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    voltage_on_q |-> (active_ch_q == apos_pkg::ChanA || active_ch_q == apos_pkg::ChanB))
    else $error("voltage on without a valid channel");

  a_chan_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_ch_q != apos_pkg::ChanInvalid)
    else $error("unused channel code reached");

  // A pulse start writes the DAC and reloads the timer, with a channel raised
  a_pwm_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && pwm_enable_q) |->
      (dac_write_q && reload_write_q && (chan_a_q ^ chan_b_q) && !gate_pin_q))
    else $error("pulse start result inconsistent");
`endif

endmodule
